// File: design/vrl_pkg.sv
// Package for the velocity ramp limiter: widths, constants, register codes and stage types.
package vrl_pkg;

  // Value format: signed fixed point
  localparam int VALUE_W = 32;
  localparam int FRAC_W  = 16;
  localparam int REG_W   = VALUE_W - 1;
  localparam int DT_W    = 16;
  localparam int IDX_W   = 3;

  // Error and ramp arithmetic
  localparam int D_W      = VALUE_W + 2;
  localparam int RAMP_W   = 2 * REG_W;
  localparam int P_W      = RAMP_W - FRAC_W;
  localparam int MAG_W    = VALUE_W + 4;
  localparam int LIM_W    = VALUE_W + 2;

  // Step delta = rate * dt / 1e6, with 1e6 = 2^6 * 15625
  localparam int RATE_PROD_W = REG_W + DT_W;
  localparam int US_SHIFT    = 6;
  localparam int US_ODD      = 15625;
  localparam int ODD_W       = 14;
  localparam int Y_W         = RATE_PROD_W - US_SHIFT;
  localparam int RECIP_W     = Y_W - ODD_W + 1;
  localparam int Q_W         = RECIP_W;
  localparam int YL_W        = (Y_W + 1) / 2;
  localparam int YH_W        = Y_W - YL_W;
  localparam int PH_W        = YH_W + RECIP_W;
  localparam int PL_W        = YL_W + RECIP_W;
  localparam int SUM_W       = Y_W + RECIP_W;

  // floor(2^Y_W / 15625): the estimate is low by at most one
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << Y_W) / 64'(US_ODD));

  localparam logic signed [MAG_W-1:0] VAL_MAX = MAG_W'((64'sd1 <<< (VALUE_W - 1)) - 64'sd1);
  localparam logic signed [MAG_W-1:0] VAL_MIN = -VAL_MAX - MAG_W'(1);
  localparam logic [P_W-1:0]          P_CAP   = P_W'(64'd1 << VALUE_W);

  // Register reset values
  localparam logic [REG_W-1:0] ONE_RST   = REG_W'(64'd1 << FRAC_W);
  localparam logic [REG_W-1:0] BRAKE_RST = REG_W'(64'd1 << (FRAC_W - 1));
  localparam logic [REG_W-1:0] SLOPE_RST = REG_W'(64'd2 << FRAC_W);

  typedef enum logic [IDX_W-1:0] {
    REG_ACCEL,
    REG_DECEL,
    REG_VMAX,
    REG_TOL,
    REG_BRAKE,
    REG_SLOPE
  } reg_idx_t;

  // Input register
  typedef struct packed {
    logic signed [VALUE_W-1:0] tp;
    logic signed [VALUE_W-1:0] mp;
    logic [DT_W-1:0]           dt;
  } s1_t;

  // Error classified, raw rate products
  typedef struct packed {
    logic                   zero;
    logic                   ramp;
    logic                   neg;
    logic                   d_neg;
    logic [REG_W-1:0]       d_abs;
    logic [RATE_PROD_W-1:0] acc_prod;
    logic [RATE_PROD_W-1:0] dec_prod;
  } s2_t;

  // Ramp product, reciprocal partial products
  typedef struct packed {
    logic              zero;
    logic              ramp;
    logic              neg;
    logic              d_neg;
    logic [RAMP_W-1:0] ramp_prod;
    logic [Y_W-1:0]    acc_y;
    logic [Y_W-1:0]    dec_y;
    logic [PH_W-1:0]   acc_ph;
    logic [PL_W-1:0]   acc_pl;
    logic [PH_W-1:0]   dec_ph;
    logic [PL_W-1:0]   dec_pl;
  } s3_t;

  // Target speed, quotient estimates
  typedef struct packed {
    logic signed [VALUE_W-1:0] v;
    logic [Y_W-1:0]            acc_y;
    logic [Y_W-1:0]            dec_y;
    logic [Q_W-1:0]            acc_q0;
    logic [Q_W-1:0]            dec_q0;
  } s4_t;

  // Target speed, exact step deltas
  typedef struct packed {
    logic signed [VALUE_W-1:0] v;
    logic [Q_W-1:0]            acc_delta;
    logic [Q_W-1:0]            dec_delta;
  } s5_t;

  // Remainder left after the quotient estimate
  function automatic logic [Y_W-1:0] div_rem(input logic [Y_W-1:0] y,
                                             input logic [Q_W-1:0] q0);
    logic [Y_W-1:0] back;
    back = Y_W'(q0) * Y_W'(US_ODD);
    return y - back;
  endfunction

endpackage

// File: design/velocity_ramp_limiter.sv
// Velocity ramp limiter: trapezoidal target speed followed by accel/decel rate limiting.
// Six register stages (input, s2..s5, output) split the multiply and add/compare work.
// Throughput: one item per cycle while out_ready does not stall the pipeline.
// The previous speed is read and written only in the last stage, so items follow back to back.
// Reset: pipeline empties, registers return to their defaults, previous speed clears to zero.
module velocity_ramp_limiter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [vrl_pkg::IDX_W-1:0]            cfg_index,
  input  logic [vrl_pkg::REG_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [vrl_pkg::VALUE_W-1:0]   target_position,
  input  logic signed [vrl_pkg::VALUE_W-1:0]   measured_position,
  input  logic [vrl_pkg::DT_W-1:0]             step_time_us,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [vrl_pkg::VALUE_W-1:0]   speed_command
);
  import vrl_pkg::*;

  // Configuration registers
  logic [REG_W-1:0] accel_rate;
  logic [REG_W-1:0] decel_rate;
  logic [REG_W-1:0] max_speed;
  logic [REG_W-1:0] position_tolerance;
  logic [REG_W-1:0] braking_distance;
  logic [REG_W-1:0] ramp_slope;

  // Stage registers and valids
  s1_t s1;
  s2_t s2;
  s3_t s3;
  s4_t s4;
  s5_t s5;
  logic vld1, vld2, vld3, vld4, vld5;
  logic adv1, adv2, adv3, adv4, adv5, adv_out;
  logic signed [VALUE_W-1:0] prev_speed;

  // Next-stage values
  s2_t s2_next;
  s3_t s3_next;
  s4_t s4_next;
  s5_t s5_next;
  logic signed [VALUE_W-1:0] result_next;

  // Stage 2 working signals
  logic signed [VALUE_W:0] err;
  logic [VALUE_W:0]        err_mag;
  logic signed [D_W-1:0]   ramp_gap;

  // Stage 4 working signals
  logic [VALUE_W:0]          p_clip;
  logic [P_W-1:0]            p_full;
  logic signed [MAG_W-1:0]   term;
  logic signed [MAG_W-1:0]   mag;
  logic signed [MAG_W-1:0]   vraw;
  logic [SUM_W-1:0]          acc_sum;
  logic [SUM_W-1:0]          dec_sum;

  // Stage 5 working signals
  logic [Y_W-1:0] acc_rem;
  logic [Y_W-1:0] dec_rem;

  // Output stage working signals
  logic                    down;
  logic                    use_dec;
  logic [Q_W-1:0]          delta;
  logic signed [LIM_W-1:0] prev_x;
  logic signed [LIM_W-1:0] v_x;
  logic signed [LIM_W-1:0] delta_x;
  logic signed [LIM_W-1:0] lim;
  logic signed [LIM_W-1:0] res_x;

  // Backpressure: a stage moves when it is empty or its successor moves
  assign adv_out  = !out_valid || out_ready;
  assign adv5     = !vld5 || adv_out;
  assign adv4     = !vld4 || adv5;
  assign adv3     = !vld3 || adv4;
  assign adv2     = !vld2 || adv3;
  assign adv1     = !vld1 || adv2;
  assign in_ready = adv1;

  // Stage 2: position error, band checks, ramp distance, rate * dt
  always_comb begin
    err      = {s1.tp[VALUE_W-1], s1.tp} - {s1.mp[VALUE_W-1], s1.mp};
    err_mag  = err[VALUE_W] ? (~err + 1'b1) : err;
    ramp_gap = $signed(D_W'(braking_distance)) - $signed(D_W'(err_mag))
             - $signed(D_W'(position_tolerance));
    s2_next.zero     = err_mag <= (VALUE_W+1)'(position_tolerance);
    s2_next.ramp     = err_mag <= (VALUE_W+1)'(braking_distance);
    s2_next.neg      = err[VALUE_W];
    s2_next.d_neg    = ramp_gap[D_W-1];
    // only meaningful inside the braking distance, where |d| fits
    s2_next.d_abs    = REG_W'(ramp_gap[D_W-1] ? -ramp_gap : ramp_gap);
    s2_next.acc_prod = RATE_PROD_W'(accel_rate) * RATE_PROD_W'(s1.dt);
    s2_next.dec_prod = RATE_PROD_W'(decel_rate) * RATE_PROD_W'(s1.dt);
  end

  // Stage 3: ramp product, reciprocal multiply split in two halves
  always_comb begin
    s3_next.zero      = s2.zero;
    s3_next.ramp      = s2.ramp;
    s3_next.neg       = s2.neg;
    s3_next.d_neg     = s2.d_neg;
    s3_next.ramp_prod = RAMP_W'(s2.d_abs) * RAMP_W'(ramp_slope);
    s3_next.acc_y     = s2.acc_prod[RATE_PROD_W-1:US_SHIFT];
    s3_next.dec_y     = s2.dec_prod[RATE_PROD_W-1:US_SHIFT];
    s3_next.acc_ph    = PH_W'(s3_next.acc_y[Y_W-1:YL_W]) * PH_W'(RECIP);
    s3_next.acc_pl    = PL_W'(s3_next.acc_y[YL_W-1:0]) * PL_W'(RECIP);
    s3_next.dec_ph    = PH_W'(s3_next.dec_y[Y_W-1:YL_W]) * PH_W'(RECIP);
    s3_next.dec_pl    = PL_W'(s3_next.dec_y[YL_W-1:0]) * PL_W'(RECIP);
  end

  // Stage 4: target speed with saturation; quotient estimates
  always_comb begin
    p_full = s3.ramp_prod[RAMP_W-1:FRAC_W];
    p_clip = (p_full > P_CAP) ? P_CAP[VALUE_W:0] : p_full[VALUE_W:0];
    term   = s3.d_neg ? -$signed(MAG_W'(p_clip)) : $signed(MAG_W'(p_clip));
    mag    = s3.ramp ? ($signed(MAG_W'(max_speed)) - term) : $signed(MAG_W'(max_speed));
    vraw   = s3.neg ? -mag : mag;
    if (s3.zero) begin
      s4_next.v = '0;
    end else if (vraw > VAL_MAX) begin
      s4_next.v = VAL_MAX[VALUE_W-1:0];
    end else if (vraw < VAL_MIN) begin
      s4_next.v = VAL_MIN[VALUE_W-1:0];
    end else begin
      s4_next.v = vraw[VALUE_W-1:0];
    end
    acc_sum        = (SUM_W'(s3.acc_ph) << YL_W) + SUM_W'(s3.acc_pl);
    dec_sum        = (SUM_W'(s3.dec_ph) << YL_W) + SUM_W'(s3.dec_pl);
    s4_next.acc_y  = s3.acc_y;
    s4_next.dec_y  = s3.dec_y;
    s4_next.acc_q0 = acc_sum[SUM_W-1:Y_W];
    s4_next.dec_q0 = dec_sum[SUM_W-1:Y_W];
  end

  // Stage 5: correct quotient estimates by one
  always_comb begin
    acc_rem           = div_rem(s4.acc_y, s4.acc_q0);
    dec_rem           = div_rem(s4.dec_y, s4.dec_q0);
    s5_next.v         = s4.v;
    s5_next.acc_delta = (acc_rem >= Y_W'(US_ODD)) ? s4.acc_q0 + 1'b1 : s4.acc_q0;
    s5_next.dec_delta = (dec_rem >= Y_W'(US_ODD)) ? s4.dec_q0 + 1'b1 : s4.dec_q0;
  end

  // Output stage: rate limit against the previous speed
  always_comb begin
    down    = prev_speed > s5.v;
    use_dec = (s5.v > 0) == down;
    delta   = use_dec ? s5.dec_delta : s5.acc_delta;
    prev_x  = LIM_W'(prev_speed);
    v_x     = LIM_W'(s5.v);
    delta_x = $signed(LIM_W'(delta));
    if (down) begin
      lim   = prev_x - delta_x;
      res_x = (lim > v_x) ? lim : v_x;
    end else begin
      lim   = prev_x + delta_x;
      res_x = (lim < v_x) ? lim : v_x;
    end
    result_next = res_x[VALUE_W-1:0];
  end

  // Control state, configuration and previous speed
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1               <= 1'b0;
      vld2               <= 1'b0;
      vld3               <= 1'b0;
      vld4               <= 1'b0;
      vld5               <= 1'b0;
      out_valid          <= 1'b0;
      prev_speed         <= '0;
      accel_rate         <= ONE_RST;
      decel_rate         <= ONE_RST;
      max_speed          <= ONE_RST;
      position_tolerance <= '0;
      braking_distance   <= BRAKE_RST;
      ramp_slope         <= SLOPE_RST;
    end else begin
      if (adv1)    vld1      <= in_valid;
      if (adv2)    vld2      <= vld1;
      if (adv3)    vld3      <= vld2;
      if (adv4)    vld4      <= vld3;
      if (adv5)    vld5      <= vld4;
      if (adv_out) out_valid <= vld5;
      if (adv_out && vld5) prev_speed <= result_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_ACCEL: accel_rate         <= cfg_data;
          REG_DECEL: decel_rate         <= cfg_data;
          REG_VMAX:  max_speed          <= cfg_data;
          REG_TOL:   position_tolerance <= cfg_data;
          REG_BRAKE: braking_distance   <= cfg_data;
          REG_SLOPE: ramp_slope         <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1.tp <= target_position;
      s1.mp <= measured_position;
      s1.dt <= step_time_us;
    end
    if (adv2 && vld1) s2 <= s2_next;
    if (adv3 && vld2) s3 <= s3_next;
    if (adv4 && vld3) s4 <= s4_next;
    if (adv5 && vld4) s5 <= s5_next;
    if (adv_out && vld5) speed_command <= result_next;
  end

`ifndef SYNTH
  // The shown result is always the stored previous speed
  a_out_is_prev: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> speed_command == prev_speed)
    else $error("speed_command differs from stored previous speed");

  // Limited speed lies between the target and the previous speed
  a_result_bounded: assert property (@(posedge clk) disable iff (rst)
    vld5 |-> ((result_next >= s5.v && result_next <= prev_speed) ||
              (result_next <= s5.v && result_next >= prev_speed)))
    else $error("limited speed outside target/previous range");

  // Reciprocal estimate is never more than one low
  a_accel_div: assert property (@(posedge clk) disable iff (rst)
    vld4 |-> acc_rem < Y_W'(2 * US_ODD))
    else $error("accel step quotient estimate off by more than one");

  a_decel_div: assert property (@(posedge clk) disable iff (rst)
    vld4 |-> dec_rem < Y_W'(2 * US_ODD))
    else $error("decel step quotient estimate off by more than one");

  // An accepted item occupies the input stage
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld1)
    else $error("accepted item lost at input stage");
`endif

endmodule

// File: verif/speed_command_checker.sv
// Checker for the velocity ramp limiter: tracks registers, predicts each speed command, compares.
module speed_command_checker
  import vrl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [REG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [VALUE_W-1:0] target_position,
  input  logic signed [VALUE_W-1:0] measured_position,
  input  logic [DT_W-1:0]           step_time_us,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [VALUE_W-1:0] speed_command,
  output int                        fail_count,
  output int                        speeds_pending
);

  typedef longint unsigned u64_t;

  localparam longint SPEED_MAX   = (64'sd1 <<< (VALUE_W - 1)) - 64'sd1;
  localparam longint SPEED_MIN   = -SPEED_MAX - 64'sd1;
  localparam u64_t   RAMP_CAP    = u64_t'(1) << VALUE_W;
  localparam longint US_PER_SEC  = 1000000;

  // Shadow copy of the profile registers and the kept speed
  logic [REG_W-1:0] accel_reg, decel_reg, vmax_reg, tol_reg, brake_reg, slope_reg;
  longint           last_speed;

  logic signed [VALUE_W-1:0] speed_expected_q [$];

  // Speed change allowed over one step: floor(rate * dt / 1e6)
  function automatic longint rate_step(input logic [REG_W-1:0] rate,
                                       input logic [DT_W-1:0] dt);
    return (longint'(rate) * longint'(dt)) / US_PER_SEC;
  endfunction

  // Trapezoidal target, then accel/decel limiting against the kept speed
  function automatic logic signed [VALUE_W-1:0] ramp_limited_speed(
      input logic signed [VALUE_W-1:0] tp,
      input logic signed [VALUE_W-1:0] mp,
      input logic [DT_W-1:0]           dt);
    longint err, err_mag, gap, gap_mag, mag, target, lim, nxt;
    u64_t   ramp;
    err     = longint'(tp) - longint'(mp);
    err_mag = (err < 0) ? -err : err;
    if (err_mag <= longint'(tol_reg)) begin
      target = 0;
    end else begin
      if (err_mag <= longint'(brake_reg)) begin
        // gap goes negative when the tolerance reaches into the ramp
        gap     = longint'(brake_reg) - err_mag - longint'(tol_reg);
        gap_mag = (gap < 0) ? -gap : gap;
        ramp    = (u64_t'(gap_mag) * u64_t'(slope_reg)) >> FRAC_W;
        if (ramp > RAMP_CAP) ramp = RAMP_CAP;
        mag = longint'(vmax_reg) - ((gap < 0) ? -longint'(ramp) : longint'(ramp));
      end else begin
        mag = longint'(vmax_reg);
      end
      target = (err > 0) ? mag : -mag;
      if (target > SPEED_MAX) target = SPEED_MAX;
      if (target < SPEED_MIN) target = SPEED_MIN;
    end
    // Limit choice by sign of target and direction of change
    if (target > 0) begin
      if (last_speed > target) begin
        lim = last_speed - rate_step(decel_reg, dt);
        nxt = (lim > target) ? lim : target;
      end else begin
        lim = last_speed + rate_step(accel_reg, dt);
        nxt = (lim < target) ? lim : target;
      end
    end else begin
      if (last_speed > target) begin
        lim = last_speed - rate_step(accel_reg, dt);
        nxt = (lim > target) ? lim : target;
      end else begin
        lim = last_speed + rate_step(decel_reg, dt);
        nxt = (lim < target) ? lim : target;
      end
    end
    last_speed = nxt;
    return VALUE_W'(nxt);
  endfunction

  always @(posedge clk) begin
    logic signed [VALUE_W-1:0] want;
    if (rst) begin
      accel_reg  = ONE_RST;
      decel_reg  = ONE_RST;
      vmax_reg   = ONE_RST;
      tol_reg    = '0;
      brake_reg  = BRAKE_RST;
      slope_reg  = SLOPE_RST;
      last_speed = 0;
      fail_count = 0;
      speed_expected_q.delete();
      speeds_pending <= 0;
    end else begin
      // Register writes; unused indexes are dropped
      if (cfg_write) begin
        case (reg_idx_t'(cfg_index))
          REG_ACCEL: accel_reg = cfg_data;
          REG_DECEL: decel_reg = cfg_data;
          REG_VMAX:  vmax_reg  = cfg_data;
          REG_TOL:   tol_reg   = cfg_data;
          REG_BRAKE: brake_reg = cfg_data;
          REG_SLOPE: slope_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        speed_expected_q.push_back(
          ramp_limited_speed(target_position, measured_position, step_time_us));
      if (out_valid && out_ready) begin
        if (speed_expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected speed_command: expected none, actual %0d",
                   $time, speed_command);
        end else begin
          want = speed_expected_q.pop_front();
          if (speed_command !== want) begin
            fail_count++;
            $display("%0t: speed_command mismatch: expected %0d, actual %0d",
                     $time, want, speed_command);
          end
        end
      end
      speeds_pending <= speed_expected_q.size();
    end
  end

endmodule

// File: verif/testbench.sv
// Top of the velocity ramp limiter testbench: clock, reset, register setup, stimulus, verdict.
module testbench;
  import vrl_pkg::*;

  typedef enum {PROFILE_TYPICAL, PROFILE_WILD, PROFILE_ALL_MAX, PROFILE_ALL_ZERO} profile_kind_t;

  localparam longint REG_LIMIT     = (64'sd1 <<< REG_W) - 64'sd1;
  localparam int     ITEMS_A_PHASE = 150;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     SETTLE_CYCLES = 12;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [IDX_W-1:0]          cfg_index = '0;
  logic [REG_W-1:0]          cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [VALUE_W-1:0] target_position = '0;
  logic signed [VALUE_W-1:0] measured_position = '0;
  logic [DT_W-1:0]           step_time_us = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] speed_command;

  int  fail_count;
  int  speeds_pending;
  int  burst_left = 0;
  logic rx_long_hold = 1'b0;

  // Profile currently loaded, used only to shape the position errors
  longint cur_tol   = 0;
  longint cur_brake = 32768;

  velocity_ramp_limiter dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .target_position   (target_position),
    .measured_position (measured_position),
    .step_time_us      (step_time_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .speed_command     (speed_command)
  );

  speed_command_checker speed_check (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .target_position   (target_position),
    .measured_position (measured_position),
    .step_time_us      (step_time_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .speed_command     (speed_command),
    .fail_count        (fail_count),
    .speeds_pending    (speeds_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // Receiver: one long hold-off on request, otherwise segments of ready patterns
  initial begin
    int  seg_left, mode, hold_left;
    bit  hold_done;
    seg_left  = 0;
    mode      = 0;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (rx_long_hold && !hold_done) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 2);
          seg_left = $urandom_range(8, 120);
        end
        seg_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Present one item and hold it until accepted; idle gaps fall between bursts
  task automatic offer_position(input logic signed [VALUE_W-1:0] tp,
                                input logic signed [VALUE_W-1:0] mp,
                                input logic [DT_W-1:0]           dt);
    int gap;
    in_valid          <= 1'b1;
    target_position   <= tp;
    measured_position <= mp;
    step_time_us      <= dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(0, 30);
    end
  endtask

  // Stop sending and wait until every predicted speed has come out
  task automatic wait_for_all_speeds();
    in_valid <= 1'b0;
    @(posedge clk);
    while (speeds_pending != 0) @(posedge clk);
  endtask

  // Write leaves the enable high; the caller lowers it after the last write
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_profile(input longint accel, input longint decel,
                                 input longint vmax, input longint tol,
                                 input longint brake, input longint slope);
    write_reg(REG_ACCEL, REG_W'(accel));
    write_reg(REG_DECEL, REG_W'(decel));
    write_reg(REG_VMAX,  REG_W'(vmax));
    write_reg(REG_TOL,   REG_W'(tol));
    write_reg(REG_BRAKE, REG_W'(brake));
    write_reg(REG_SLOPE, REG_W'(slope));
    // Indexes past the last register must be ignored
    for (int i = int'(REG_SLOPE) + 1; i < (1 << IDX_W); i++)
      write_reg(IDX_W'(i), REG_W'($urandom));
    cfg_write <= 1'b0;
    cur_tol   = tol;
    cur_brake = brake;
  endtask

  task automatic pick_profile(input profile_kind_t kind);
    longint vmax, accel, decel, brake, slope, tol;
    case (kind)
      PROFILE_TYPICAL: begin
        // Braking distance and slope as software would derive them
        vmax  = $urandom_range(32'h0000_1000, 32'h0032_0000);
        accel = $urandom_range(32'h0000_4000, 32'h00C8_0000);
        decel = $urandom_range(32'h0000_4000, 32'h00C8_0000);
        brake = (vmax * vmax) / (2 * decel);
        if (brake > REG_LIMIT) brake = REG_LIMIT;
        slope = (brake == 0) ? REG_LIMIT : (vmax <<< FRAC_W) / brake;
        if (slope > REG_LIMIT) slope = REG_LIMIT;
        tol   = $urandom_range(0, 32'(brake / 8));
      end
      PROFILE_WILD: begin
        vmax  = $urandom_range(0, 32'(REG_LIMIT));
        accel = $urandom_range(0, 32'(REG_LIMIT));
        decel = $urandom_range(0, 32'(REG_LIMIT));
        brake = $urandom_range(0, 32'(REG_LIMIT));
        slope = $urandom_range(0, 32'(REG_LIMIT));
        tol   = $urandom_range(0, 32'(brake));
      end
      PROFILE_ALL_MAX: begin
        vmax  = REG_LIMIT;
        accel = REG_LIMIT;
        decel = REG_LIMIT;
        brake = REG_LIMIT;
        slope = REG_LIMIT;
        tol   = REG_LIMIT;
      end
      default: begin
        vmax  = 0;
        accel = 0;
        decel = 0;
        brake = 0;
        slope = 0;
        tol   = 0;
      end
    endcase
    program_profile(accel, decel, vmax, tol, brake, slope);
  endtask

  // Errors mostly land in the tolerance band, the ramp or just past it
  task automatic run_random_phase(input int count);
    int                        pick;
    longint                    err;
    logic signed [VALUE_W-1:0] mp, tp;
    logic [DT_W-1:0]           dt;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 9);
      mp   = $urandom;
      if (pick < 2)
        err = $urandom_range(0, 32'(cur_tol));
      else if (pick < 6)
        err = $urandom_range(32'(cur_tol), 32'(cur_brake));
      else if (pick < 8)
        err = cur_brake + $urandom_range(0, 32'h0010_0000);
      else
        err = longint'($urandom) - longint'(mp);
      if ($urandom_range(0, 1) == 1) err = -err;
      tp = VALUE_W'(longint'(mp) + err);
      case ($urandom_range(0, 7))
        0:       dt = '0;
        1:       dt = '1;
        2:       dt = DT_W'($urandom);
        default: dt = DT_W'($urandom_range(500, 20000));
      endcase
      offer_position(tp, mp, dt);
    end
  endtask

  initial begin
    profile_kind_t plan [8];
    plan = '{PROFILE_TYPICAL, PROFILE_WILD, PROFILE_TYPICAL, PROFILE_ALL_MAX,
             PROFILE_TYPICAL, PROFILE_ALL_ZERO, PROFILE_WILD, PROFILE_TYPICAL};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset profile: zero error, full-scale errors both ways, zero step time
    offer_position(32'sd0, 32'sd0, 16'd1000);
    offer_position(32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF);
    offer_position(32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF);
    offer_position(32'sh0000_4000, 32'sd0, 16'd0);
    wait_for_all_speeds();

    // Tolerance reaching into the ramp: target overshoots max speed
    program_profile(REG_LIMIT, REG_LIMIT, 64'h000A_0000, 64'h0002_0000,
                    64'h0003_0000, 64'h0004_0000);
    offer_position(32'sh0002_8000, 32'sd0, 16'hFFFF);
    offer_position(32'sd0, 32'sh0002_8000, 16'hFFFF);
    offer_position(32'sh0002_0000, 32'sd0, 16'd20000);
    offer_position(32'sh0003_0000, 32'sd0, 16'd20000);
    offer_position(32'sd6553600, -32'sd6553600, 16'd1);
    offer_position(-32'sd6553600, 32'sd6553600, 16'd0);
    wait_for_all_speeds();

    // Huge ramp product, zero max speed, zero decel
    program_profile(REG_LIMIT, 0, 0, 0, REG_LIMIT, REG_LIMIT);
    offer_position(32'sd1, 32'sd0, 16'hFFFF);
    offer_position(-32'sd1, 32'sd0, 16'hFFFF);
    offer_position(32'sh7FFF_FFFF, -32'sd1, 16'd50000);
    offer_position(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'd0);
    offer_position(32'sh8000_0000, 32'sd1, 16'd30000);
    wait_for_all_speeds();

    // Random phases, one profile each; first one gets the long receiver hold
    foreach (plan[p]) begin
      pick_profile(plan[p]);
      if (p == 0) rx_long_hold <= 1'b1;
      run_random_phase(ITEMS_A_PHASE);
      wait_for_all_speeds();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && speeds_pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
